// ===== rtl/blist_pkg.sv =====
`timescale 1ns / 1ps

package blist_pkg;

  localparam int unsigned DefDepth = 16;
  localparam int unsigned OutLimit = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned PosW     = 4;

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_DELETE = 2'd2,
    FUNC_DUMP   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_DONE  = 3'd0,
    ST_FULL  = 3'd1,
    ST_NONE  = 3'd2,
    ST_ELEM  = 3'd3,
    ST_EMPTY = 3'd4
  } status_e;

  typedef struct packed {
    status_e                   status;
    logic signed [DataW-1:0]   element;
    logic                      last;
  } res_t;

endpackage

// ===== rtl/blist_if.sv =====
`timescale 1ns / 1ps

interface blist_in_if;
  logic                                    valid;
  logic                                    ready;
  blist_pkg::func_e                        func;
  logic signed [blist_pkg::DataW-1:0]      value;
  logic        [blist_pkg::PosW-1:0]       position;

  modport source (output valid, func, value, position, input ready);
  modport sink   (input valid, func, value, position, output ready);
endinterface

interface blist_out_if;
  logic                                    valid;
  logic                                    ready;
  blist_pkg::status_e                      status;
  logic signed [blist_pkg::DataW-1:0]      element;
  logic                                    last;

  modport source (output valid, status, element, last, input ready);
  modport sink   (input valid, status, element, last, output ready);
endinterface

// ===== rtl/blist_slot.sv =====
`timescale 1ns / 1ps

module blist_slot #(
  parameter int unsigned DEPTH = blist_pkg::DefDepth
) (
  input  logic [$clog2(DEPTH)-1:0] front_i,
  input  logic [$clog2(DEPTH)-1:0] offset_i,
  output logic [$clog2(DEPTH)-1:0] slot_o
);
  import blist_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic [AW:0] sum;

  // front + offset is below twice the depth: one compare and subtract wraps it
  assign sum = {1'b0, front_i} + {1'b0, offset_i};

  always_comb begin
    if (sum >= (AW+1)'(DEPTH)) begin
      slot_o = AW'(sum - (AW+1)'(DEPTH));
    end else begin
      slot_o = sum[AW-1:0];
    end
  end

endmodule

// ===== rtl/blist_mem.sv =====
`timescale 1ns / 1ps

module blist_mem #(
  parameter int unsigned DEPTH = blist_pkg::DefDepth
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [$clog2(DEPTH)-1:0]          waddr_i,
  input  logic signed [blist_pkg::DataW-1:0] wdata_i,
  input  logic                              re_i,
  input  logic [$clog2(DEPTH)-1:0]          raddr_i,
  output logic signed [blist_pkg::DataW-1:0] rdata_o
);
  import blist_pkg::*;

  logic signed [DataW-1:0] mem_q [DEPTH];
  logic signed [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/blist_ctrl.sv =====
`timescale 1ns / 1ps

module blist_ctrl #(
  parameter int unsigned DEPTH = blist_pkg::DefDepth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  blist_pkg::func_e                   func_i,
  input  logic signed [blist_pkg::DataW-1:0] value_i,
  input  logic [blist_pkg::PosW-1:0]         position_i,
  output logic                               res_valid_o,
  output blist_pkg::res_t                    res_o,
  input  logic                               out_free_i
);
  import blist_pkg::*;

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CW > 5) ? CW : 5;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_DUMP  = 5'b01000,
    S_RESP  = 5'b10000
  } state_e;

  state_e                  state_q, state_d;
  func_e                   func_q;
  logic signed [DataW-1:0] value_q;
  logic [PosW-1:0]         pos_q;
  logic [CW-1:0]           count_q, count_d;
  logic [AW-1:0]           front_q, front_d;
  logic [CW-1:0]           k_q, k_d;
  logic [CW-1:0]           n_q, n_d;
  logic [AW-1:0]           last_slot_q, last_slot_d;
  logic [AW-1:0]           wr_slot_q, wr_slot_d;
  logic                    pend_q, pend_d;
  status_e                 status_q, status_d;

  logic [AW-1:0]           offset;
  logic [AW-1:0]           slot;
  logic                    full;
  logic                    del_miss;
  logic                    issue;
  logic                    emit;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic signed [DataW-1:0] mem_wdata;
  logic                    mem_re;
  logic signed [DataW-1:0] mem_rdata;

  blist_slot #(.DEPTH(DEPTH)) u_slot (
    .front_i  (front_q),
    .offset_i (offset),
    .slot_o   (slot)
  );

  blist_mem #(.DEPTH(DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (slot),
    .rdata_o (mem_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign full       = (count_q == CW'(DEPTH));
  assign del_miss   = (CmpW'(pos_q) >= CmpW'(count_q));
  // dump: read ahead while the fetched word can move on this cycle
  assign emit       = pend_q && out_free_i;
  assign issue      = (k_q < n_q) && (!pend_q || out_free_i);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    front_d      = front_q;
    k_d          = k_q;
    n_d          = n_q;
    last_slot_d  = last_slot_q;
    wr_slot_d    = wr_slot_q;
    pend_d       = pend_q;
    status_d     = status_q;
    offset       = k_q[AW-1:0];
    mem_we       = 1'b0;
    mem_waddr    = slot;
    mem_wdata    = value_q;
    mem_re       = 1'b0;
    res_valid_o  = 1'b0;
    res_o.status  = status_q;
    res_o.element = '0;
    res_o.last    = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (func_q) inside
          FUNC_APPEND, FUNC_INSERT: begin
            offset = (func_q == FUNC_APPEND) ? count_q[AW-1:0] : AW'(DEPTH - 1);
            if (full) begin
              status_d = ST_FULL;
            end else begin
              mem_we   = 1'b1;
              count_d  = count_q + CW'(1);
              status_d = ST_DONE;
              if (func_q == FUNC_INSERT) begin
                front_d = slot;
              end
            end
            state_d = S_RESP;
          end
          FUNC_DELETE: begin
            offset = AW'(pos_q);
            if (del_miss) begin
              status_d = ST_NONE;
              state_d  = S_RESP;
            end else begin
              last_slot_d = slot;
              k_d         = CW'(pos_q) + CW'(1);
              pend_d      = 1'b0;
              state_d     = S_SHIFT;
            end
          end
          default: begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_RESP;
            end else begin
              k_d     = '0;
              pend_d  = 1'b0;
              n_d     = (CmpW'(count_q) > CmpW'(OutLimit)) ? CW'(OutLimit) : count_q;
              state_d = S_DUMP;
            end
          end
        endcase
      end
      S_SHIFT: begin
        // move the word read last cycle one place toward the front
        mem_we    = pend_q;
        mem_waddr = wr_slot_q;
        mem_wdata = mem_rdata;
        pend_d    = 1'b0;
        if (k_q < count_q) begin
          mem_re      = 1'b1;
          pend_d      = 1'b1;
          wr_slot_d   = last_slot_q;
          last_slot_d = slot;
          k_d         = k_q + CW'(1);
        end else begin
          count_d  = count_q - CW'(1);
          status_d = ST_DONE;
          state_d  = S_RESP;
        end
      end
      S_DUMP: begin
        res_o.status  = ST_ELEM;
        res_o.element = mem_rdata;
        res_o.last    = (k_q == n_q);
        res_valid_o   = emit;
        if (issue) begin
          mem_re = 1'b1;
          k_d    = k_q + CW'(1);
        end
        pend_d = issue || (pend_q && !out_free_i);
        if (emit && (k_q == n_q)) begin
          state_d = S_IDLE;
        end
      end
      S_RESP: begin
        res_valid_o = out_free_i;
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      front_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      front_q <= front_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q         <= k_d;
    n_q         <= n_d;
    last_slot_q <= last_slot_d;
    wr_slot_q   <= wr_slot_d;
    status_q    <= status_d;
    if (in_valid_i && in_ready_o) begin
      func_q  <= func_i;
      value_q <= value_i;
      pos_q   <= position_i;
    end
  end

endmodule

// ===== rtl/bounded_list_with_positional_delete.sv =====
// channel | dir | fields                      | handshake
// in_i    | in  | func, value, position        | valid/ready
// out_o   | out | status, element, last        | valid/ready
//
// Append and insert pass through the execute and response states to the status word.
// Delete moves each element behind the deleted position one place toward the front,
// one at a time through the one read port and one write port of the element store.
// Dump gives one word per cycle while the output is free, at most 16 words.
// Reset clears the count and front pointer; the store needs no clearing pass.
// A stalled output holds its word; a dump pauses until it drains.
`timescale 1ns / 1ps

module bounded_list_with_positional_delete #(
  parameter int unsigned DEPTH = blist_pkg::DefDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  blist_in_if.sink    in_i,
  blist_out_if.source out_o
);
  import blist_pkg::*;

  logic ctrl_res_valid;
  res_t ctrl_res;
  logic ctrl_in_ready;
  logic out_free;
  logic out_valid_q;
  res_t out_q;

  assign out_free = !out_valid_q || out_o.ready;

  blist_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (ctrl_in_ready),
    .func_i      (in_i.func),
    .value_i     (in_i.value),
    .position_i  (in_i.position),
    .res_valid_o (ctrl_res_valid),
    .res_o       (ctrl_res),
    .out_free_i  (out_free)
  );

  assign in_i.ready = ctrl_in_ready;

  // output register: load a new word when empty or when the held one is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_res_valid) begin
      out_q <= ctrl_res;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.status  = out_q.status;
  assign out_o.element = out_q.element;
  assign out_o.last    = out_q.last;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_res_valid |-> (!out_valid_q || out_o.ready))
    else $error("result loaded over a pending output word");

  a_busy_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_in_ready && ctrl_res_valid))
    else $error("input ready while a result is produced");

  a_dump_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_res_valid && !ctrl_res.last) |=> !ctrl_in_ready)
    else $error("new item taken before the dump finished");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input ready right after acceptance");

endmodule
